### design/qpi_pkg.sv
// Shared types, constants and tables for the quaternion pose integrator.
// Holds the sequencer states, the multiply request bundle and the arctangent table.
// Depends on nothing; qpi_mac and the top level import it, qpi_if does not.
`timescale 1ns / 1ps

package qpi_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int CORDIC_STEPS_MAX = 30;

    localparam int MAC_W     = 40;
    localparam int MAC_DIGIT = 8;
    localparam int MAC_NDIG  = MAC_W / MAC_DIGIT;

    localparam int ANG_W = 38;
    localparam int CRD_W = 36;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 38'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 38'sd1686629713;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 38'sd6746518852;
    localparam logic signed [CRD_W-1:0] GAIN_Q30    = 36'sd652032874;
    localparam logic [19:0]             MOUSE_K     = 20'd536871;
    localparam logic signed [31:0]      Q_INIT      = 32'sd759250125;
    localparam logic [31:0]             SPEED_RST   = 32'd65536;
    localparam logic [46:0]             RADIUS_RST  = 47'd417595392000;

    typedef enum logic [1:0] {
        REG_MOVE_SPEED   = 2'd0,
        REG_START_RADIUS = 2'd1
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_REDUCE,
        ST_CORDIC,
        ST_QMUL,
        ST_COMMIT,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_CROSS1,
        ST_CROSS2,
        ST_TWIST,
        ST_STEP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                    start;
        logic signed [MAC_W-1:0] a1;
        logic signed [MAC_W-1:0] b1;
        logic signed [MAC_W-1:0] a2;
        logic signed [MAC_W-1:0] b2;
    } t_mac_req;

    function automatic logic [31:0] qpi_atan(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd843314857;
            5'd1:  v = 32'd497837829;
            5'd2:  v = 32'd263043837;
            5'd3:  v = 32'd133525159;
            5'd4:  v = 32'd67021687;
            5'd5:  v = 32'd33543516;
            5'd6:  v = 32'd16775851;
            5'd7:  v = 32'd8388437;
            5'd8:  v = 32'd4194283;
            5'd9:  v = 32'd2097149;
            5'd10: v = 32'd1048576;
            5'd11: v = 32'd524288;
            5'd12: v = 32'd262144;
            5'd13: v = 32'd131072;
            5'd14: v = 32'd65536;
            5'd15: v = 32'd32768;
            5'd16: v = 32'd16384;
            5'd17: v = 32'd8192;
            5'd18: v = 32'd4096;
            5'd19: v = 32'd2048;
            5'd20: v = 32'd1024;
            5'd21: v = 32'd512;
            5'd22: v = 32'd256;
            5'd23: v = 32'd128;
            5'd24: v = 32'd64;
            5'd25: v = 32'd32;
            5'd26: v = 32'd16;
            5'd27: v = 32'd8;
            5'd28: v = 32'd4;
            5'd29: v = 32'd2;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

### design/qpi_if.sv
// Handshake channels of the pose integrator: tick beats in, pose beats out.
// Each carries valid, ready and the payload fields. No dependencies.
`timescale 1ns / 1ps

interface qpi_tick_if;
    logic               valid;
    logic               ready;
    logic        [15:0] tick_dt;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic signed [15:0] move_z;

    modport source(output valid, tick_dt, rate_x, rate_y, rate_z, mouse_dx, mouse_dy,
                   move_x, move_y, move_z, input ready);
    modport sink(input valid, tick_dt, rate_x, rate_y, rate_z, mouse_dx, mouse_dy,
                 move_x, move_y, move_z, output ready);
endinterface

interface qpi_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [47:0] pos_z;

    modport source(output valid, quat_w, quat_x, quat_y, quat_z, pos_x, pos_y, pos_z,
                   input ready);
    modport sink(input valid, quat_w, quat_x, quat_y, quat_z, pos_x, pos_y, pos_z,
                 output ready);
endinterface

### design/qpi_mac.sv
// Digit-serial multiply-accumulate unit: two signed products summed, modulo 2^64.
// Consumes the multipliers eight bits per cycle, most significant digit first.
// Depends on qpi_pkg.
`timescale 1ns / 1ps

module qpi_mac import qpi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mac_req    i_req,
    output logic        o_done,
    output logic [63:0] o_acc
);

    localparam int CNT_W = $clog2(MAC_NDIG);

    logic signed [MAC_W-1:0] r_a1, r_a2;
    logic        [MAC_W-1:0] r_b1, r_b2;
    logic        [63:0]      r_acc;
    logic        [CNT_W-1:0] r_cnt;
    logic                    r_busy;
    logic                    r_done;

    logic                            w_first;
    logic        [MAC_DIGIT-1:0]     w_d1, w_d2;
    logic signed [MAC_DIGIT:0]       w_e1, w_e2;
    logic signed [MAC_W+MAC_DIGIT:0] w_p1, w_p2;
    logic        [63:0]              w_sum;

    // The leading digit carries the sign, the rest are unsigned.
    assign w_first = (r_cnt == '0);
    assign w_d1    = r_b1[MAC_W-1 -: MAC_DIGIT];
    assign w_d2    = r_b2[MAC_W-1 -: MAC_DIGIT];
    assign w_e1    = $signed({w_first & w_d1[MAC_DIGIT-1], w_d1});
    assign w_e2    = $signed({w_first & w_d2[MAC_DIGIT-1], w_d2});
    assign w_p1    = r_a1 * w_e1;
    assign w_p2    = r_a2 * w_e2;
    assign w_sum   = (r_acc << MAC_DIGIT) + 64'(w_p1) + 64'(w_p2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MAC_NDIG - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_a1  <= i_req.a1;
            r_a2  <= i_req.a2;
            r_b1  <= i_req.b1;
            r_b2  <= i_req.b2;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= w_sum;
            r_b1  <= r_b1 << MAC_DIGIT;
            r_b2  <= r_b2 << MAC_DIGIT;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

### design/quaternion_pose_integrator_unit.sv
// Quaternion pose integrator top level: sequencer, CORDIC, square root and divider.
// Depends on qpi_pkg, the channels in qpi_if and the multiply unit qpi_mac.
//
// Usage: each beat on i_tick carries a time step, three body rates, two mouse
// deltas and a body-frame motion request. The block turns the orientation by
// five axis rotations, moves the position along the rotated, normalised motion
// vector and offers one beat on o_pose with the new orientation and position.
// The user must write configuration through i_cfg_we, i_cfg_idx and i_cfg_data
// only while the block is idle; the block itself does not enforce this. Writing
// the start radius also resets the position. Timing: one beat at a time. Each
// rotation runs the angle product, range reduction, CORDIC_STEPS CORDIC iterations
// (at most CORDIC_STEPS_MAX) and four quaternion products. A nonzero motion
// request adds 32 square root steps, three divisions and fourteen products on
// the digit-serial multiplier. The result sits in an output register; a new tick
// beat is taken while it waits. If the receiver stalls with a result still held,
// the next result waits in the sequencer. Reset restores the orientation,
// position and speed to their defaults and empties the output register.
`timescale 1ns / 1ps

module quaternion_pose_integrator_unit import qpi_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    qpi_tick_if.sink     i_tick,
    qpi_pose_if.source   o_pose,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [46:0]  i_cfg_data
);

    localparam int STEPS = (CORDIC_STEPS > CORDIC_STEPS_MAX) ? CORDIC_STEPS_MAX : CORDIC_STEPS;

    t_state r_state, n_state;

    logic        [15:0]      r_dt;
    logic signed [15:0]      r_rate[3];
    logic signed [15:0]      r_mouse[2];
    logic signed [15:0]      r_move[3];
    logic signed [31:0]      r_q[4];
    logic signed [31:0]      r_qn[4];
    logic        [47:0]      r_pos[3];
    logic        [31:0]      r_speed;
    logic        [2:0]       r_rot;
    logic        [1:0]       r_sub;
    logic                    r_wait;
    logic        [4:0]       r_cnt;
    logic                    r_neg;
    logic signed [ANG_W-1:0] r_h;
    logic signed [CRD_W-1:0] r_cx, r_cy, r_cz;
    logic        [31:0]      r_sq;
    logic        [63:0]      r_rad, r_res, r_bit;
    logic        [32:0]      r_len;
    logic        [34:0]      r_rem;
    logic        [30:0]      r_quo;
    logic signed [31:0]      r_u[3];
    logic signed [33:0]      r_uv[3];
    logic signed [33:0]      r_uuv[3];
    logic signed [37:0]      r_v;
    logic                    r_out_valid;
    logic signed [31:0]      r_oq[4];
    logic        [47:0]      r_opos[3];

    t_mac_req                w_req;
    logic                    w_mac_done;
    logic        [63:0]      w_acc;
    logic signed [33:0]      w_hi;
    logic        [31:0]      w_sqsum;
    logic        [1:0]       w_axis;
    logic signed [MAC_W-1:0] w_ew, w_ex, w_ey, w_ez, w_ec, w_es;
    logic signed [CRD_W-1:0] w_dx, w_dy, w_at, w_nx, w_ny, w_nz;
    logic        [63:0]      w_try, w_res_next;
    logic                    w_ge;
    logic        [15:0]      w_mag;
    logic        [34:0]      w_rem2;
    logic                    w_ge_d;
    logic        [30:0]      w_qn;
    logic signed [31:0]      w_uq;
    logic signed [34:0]      w_t;
    logic signed [35:0]      w_t2;
    logic                    w_load_out;

    qpi_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_mac_done),
        .o_acc   (w_acc)
    );

    assign w_hi    = $signed(w_acc[63:30]);
    assign w_sqsum = r_sq + w_acc[31:0];
    assign w_axis  = (r_rot == 3'd3) ? 2'd0 : (r_rot == 3'd4) ? 2'd1 : r_rot[1:0];

    assign w_ew = MAC_W'(r_q[0]);
    assign w_ex = MAC_W'(r_q[1]);
    assign w_ey = MAC_W'(r_q[2]);
    assign w_ez = MAC_W'(r_q[3]);
    assign w_ec = MAC_W'(r_cx);
    assign w_es = MAC_W'(r_cy);

    assign w_dx = r_cy >>> r_cnt;
    assign w_dy = r_cx >>> r_cnt;
    assign w_at = $signed({{(CRD_W-32){1'b0}}, qpi_atan(r_cnt)});
    assign w_nx = r_cz[CRD_W-1] ? r_cx + w_dx : r_cx - w_dx;
    assign w_ny = r_cz[CRD_W-1] ? r_cy - w_dy : r_cy + w_dy;
    assign w_nz = r_cz[CRD_W-1] ? r_cz + w_at : r_cz - w_at;

    assign w_try      = r_res + r_bit;
    assign w_ge       = (r_rad >= w_try);
    assign w_res_next = w_ge ? (r_res >> 1) + r_bit : (r_res >> 1);

    assign w_mag  = r_move[r_sub][15] ? 16'(-r_move[r_sub]) : 16'(r_move[r_sub]);
    assign w_rem2 = {r_rem[33:0], 1'b0};
    assign w_ge_d = (w_rem2 >= {2'b00, r_len});
    assign w_qn   = {r_quo[29:0], w_ge_d};
    assign w_uq   = $signed({1'b0, w_qn});

    assign w_t  = 35'(w_hi) + 35'(r_uuv[r_sub]);
    assign w_t2 = $signed({w_t, 1'b0});

    assign w_load_out = !r_out_valid || o_pose.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_req   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_tick.valid) begin
                    n_state = ST_ANGLE;
                end
            end
            ST_ANGLE: begin
                w_req.start = !r_wait;
                case (r_rot)
                    3'd0: begin
                        w_req.a1 = MAC_W'(r_rate[0]);
                        w_req.b1 = MAC_W'(r_dt);
                    end
                    3'd1: begin
                        w_req.a1 = MAC_W'(r_rate[1]);
                        w_req.b1 = MAC_W'(r_dt);
                    end
                    3'd2: begin
                        w_req.a1 = MAC_W'(r_rate[2]);
                        w_req.b1 = MAC_W'(r_dt);
                    end
                    3'd3: begin
                        w_req.a1 = MAC_W'(r_mouse[0]);
                        w_req.b1 = MAC_W'(MOUSE_K);
                    end
                    default: begin
                        w_req.a1 = MAC_W'(r_mouse[1]);
                        w_req.b1 = MAC_W'(MOUSE_K);
                    end
                endcase
                if (w_mac_done) begin
                    n_state = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (r_h <= PI_Q30 && r_h >= -PI_Q30) begin
                    n_state = ST_CORDIC;
                end
            end
            ST_CORDIC: begin
                if (r_cnt == 5'(STEPS - 1)) begin
                    n_state = ST_QMUL;
                end
            end
            ST_QMUL: begin
                w_req.start = !r_wait;
                case (w_axis)
                    2'd0: begin
                        case (r_sub)
                            2'd0: begin
                                w_req.a1 = w_ew; w_req.b1 = w_ec;
                                w_req.a2 = -w_ex; w_req.b2 = w_es;
                            end
                            2'd1: begin
                                w_req.a1 = w_ew; w_req.b1 = w_es;
                                w_req.a2 = w_ex; w_req.b2 = w_ec;
                            end
                            2'd2: begin
                                w_req.a1 = w_ey; w_req.b1 = w_ec;
                                w_req.a2 = w_ez; w_req.b2 = w_es;
                            end
                            default: begin
                                w_req.a1 = w_ez; w_req.b1 = w_ec;
                                w_req.a2 = -w_ey; w_req.b2 = w_es;
                            end
                        endcase
                    end
                    2'd1: begin
                        case (r_sub)
                            2'd0: begin
                                w_req.a1 = w_ew; w_req.b1 = w_ec;
                                w_req.a2 = -w_ey; w_req.b2 = w_es;
                            end
                            2'd1: begin
                                w_req.a1 = w_ex; w_req.b1 = w_ec;
                                w_req.a2 = -w_ez; w_req.b2 = w_es;
                            end
                            2'd2: begin
                                w_req.a1 = w_ew; w_req.b1 = w_es;
                                w_req.a2 = w_ey; w_req.b2 = w_ec;
                            end
                            default: begin
                                w_req.a1 = w_ez; w_req.b1 = w_ec;
                                w_req.a2 = w_ex; w_req.b2 = w_es;
                            end
                        endcase
                    end
                    default: begin
                        case (r_sub)
                            2'd0: begin
                                w_req.a1 = w_ew; w_req.b1 = w_ec;
                                w_req.a2 = -w_ez; w_req.b2 = w_es;
                            end
                            2'd1: begin
                                w_req.a1 = w_ex; w_req.b1 = w_ec;
                                w_req.a2 = w_ey; w_req.b2 = w_es;
                            end
                            2'd2: begin
                                w_req.a1 = w_ey; w_req.b1 = w_ec;
                                w_req.a2 = -w_ex; w_req.b2 = w_es;
                            end
                            default: begin
                                w_req.a1 = w_ew; w_req.b1 = w_es;
                                w_req.a2 = w_ez; w_req.b2 = w_ec;
                            end
                        endcase
                    end
                endcase
                if (w_mac_done && r_sub == 2'd3) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                n_state = (r_rot == 3'd4) ? ST_SQ : ST_ANGLE;
            end
            ST_SQ: begin
                w_req.start = !r_wait;
                if (r_sub == 2'd0) begin
                    w_req.a1 = MAC_W'(r_move[0]); w_req.b1 = MAC_W'(r_move[0]);
                    w_req.a2 = MAC_W'(r_move[1]); w_req.b2 = MAC_W'(r_move[1]);
                end else begin
                    w_req.a1 = MAC_W'(r_move[2]); w_req.b1 = MAC_W'(r_move[2]);
                end
                if (w_mac_done && r_sub == 2'd1) begin
                    n_state = (w_sqsum == '0) ? ST_DONE : ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (r_bit[0]) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_wait && r_cnt == 5'd30 && r_sub == 2'd2) begin
                    n_state = ST_CROSS1;
                end
            end
            ST_CROSS1, ST_CROSS2: begin
                w_req.start = !r_wait;
                case (r_sub)
                    2'd0: begin
                        w_req.a1 = w_ey;  w_req.a2 = -w_ez;
                        w_req.b1 = (r_state == ST_CROSS1) ? MAC_W'(r_u[2]) : MAC_W'(r_uv[2]);
                        w_req.b2 = (r_state == ST_CROSS1) ? MAC_W'(r_u[1]) : MAC_W'(r_uv[1]);
                    end
                    2'd1: begin
                        w_req.a1 = w_ez;  w_req.a2 = -w_ex;
                        w_req.b1 = (r_state == ST_CROSS1) ? MAC_W'(r_u[0]) : MAC_W'(r_uv[0]);
                        w_req.b2 = (r_state == ST_CROSS1) ? MAC_W'(r_u[2]) : MAC_W'(r_uv[2]);
                    end
                    default: begin
                        w_req.a1 = w_ex;  w_req.a2 = -w_ey;
                        w_req.b1 = (r_state == ST_CROSS1) ? MAC_W'(r_u[1]) : MAC_W'(r_uv[1]);
                        w_req.b2 = (r_state == ST_CROSS1) ? MAC_W'(r_u[0]) : MAC_W'(r_uv[0]);
                    end
                endcase
                if (w_mac_done && r_sub == 2'd2) begin
                    n_state = (r_state == ST_CROSS1) ? ST_CROSS2 : ST_TWIST;
                end
            end
            ST_TWIST: begin
                w_req.start = !r_wait;
                w_req.a1    = w_ew;
                w_req.b1    = MAC_W'(r_uv[r_sub]);
                if (w_mac_done) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                w_req.start = !r_wait;
                w_req.a1    = MAC_W'(r_v);
                w_req.b1    = MAC_W'(r_speed);
                if (w_mac_done) begin
                    n_state = (r_sub == 2'd2) ? ST_DONE : ST_TWIST;
                end
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q[0]      <= Q_INIT;
            r_q[1]      <= Q_INIT;
            r_q[2]      <= '0;
            r_q[3]      <= '0;
            r_pos[0]    <= '0;
            r_pos[1]    <= '0;
            r_pos[2]    <= 48'(RADIUS_RST);
            r_speed     <= SPEED_RST;
            r_out_valid <= 1'b0;
            r_wait      <= 1'b0;
            r_sub       <= '0;
            r_rot       <= '0;
            r_cnt       <= '0;
        end else begin
            if (r_state == ST_DONE && w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_pose.valid && o_pose.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_tick.valid) begin
                        r_rot  <= '0;
                        r_sub  <= '0;
                        r_wait <= 1'b0;
                    end
                end
                ST_ANGLE: begin
                    r_wait <= !w_mac_done;
                end
                ST_REDUCE: begin
                    r_cnt <= '0;
                end
                ST_CORDIC: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'(STEPS - 1)) begin
                        r_sub  <= '0;
                        r_wait <= 1'b0;
                    end
                end
                ST_QMUL: begin
                    r_wait <= !w_mac_done;
                    if (w_mac_done) begin
                        r_sub <= r_sub + 1'b1;
                    end
                end
                ST_COMMIT: begin
                    r_rot <= r_rot + 1'b1;
                    r_sub <= '0;
                end
                ST_SQ: begin
                    r_wait <= !w_mac_done;
                    if (w_mac_done) begin
                        r_sub <= (r_sub == 2'd1) ? 2'd0 : r_sub + 1'b1;
                    end
                end
                ST_SQRT: begin
                    r_sub  <= '0;
                    r_wait <= 1'b0;
                end
                ST_DIV: begin
                    if (!r_wait) begin
                        r_cnt  <= '0;
                        r_wait <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == 5'd30) begin
                            r_wait <= 1'b0;
                            r_sub  <= (r_sub == 2'd2) ? 2'd0 : r_sub + 1'b1;
                        end
                    end
                end
                ST_CROSS1, ST_CROSS2: begin
                    r_wait <= !w_mac_done;
                    if (w_mac_done) begin
                        r_sub <= (r_sub == 2'd2) ? 2'd0 : r_sub + 1'b1;
                    end
                end
                ST_TWIST: begin
                    r_wait <= !w_mac_done;
                end
                ST_STEP: begin
                    r_wait <= !w_mac_done;
                    if (w_mac_done) begin
                        r_pos[r_sub] <= r_pos[r_sub] + 48'(w_hi);
                        r_sub        <= (r_sub == 2'd2) ? 2'd0 : r_sub + 1'b1;
                    end
                end
                default: begin
                    r_wait <= 1'b0;
                end
            endcase
            if (r_state == ST_COMMIT) begin
                r_q <= r_qn;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_MOVE_SPEED) begin
                    r_speed <= i_cfg_data[31:0];
                end else if (i_cfg_idx == REG_START_RADIUS) begin
                    r_pos[0] <= '0;
                    r_pos[1] <= '0;
                    r_pos[2] <= 48'(i_cfg_data);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_tick.valid) begin
                    r_dt       <= i_tick.tick_dt;
                    r_rate[0]  <= i_tick.rate_x;
                    r_rate[1]  <= i_tick.rate_y;
                    r_rate[2]  <= i_tick.rate_z;
                    r_mouse[0] <= i_tick.mouse_dx;
                    r_mouse[1] <= i_tick.mouse_dy;
                    r_move[0]  <= i_tick.move_x;
                    r_move[1]  <= i_tick.move_y;
                    r_move[2]  <= i_tick.move_z;
                end
            end
            ST_ANGLE: begin
                if (w_mac_done) begin
                    r_h <= $signed(w_acc[ANG_W-1:0]);
                end
            end
            ST_REDUCE: begin
                r_cx <= GAIN_Q30;
                r_cy <= '0;
                if (r_h > PI_Q30) begin
                    r_h <= r_h - TWO_PI_Q30;
                end else if (r_h < -PI_Q30) begin
                    r_h <= r_h + TWO_PI_Q30;
                end else if (r_h > HALF_PI_Q30) begin
                    r_cz  <= CRD_W'(r_h - PI_Q30);
                    r_neg <= 1'b1;
                end else if (r_h < -HALF_PI_Q30) begin
                    r_cz  <= CRD_W'(r_h + PI_Q30);
                    r_neg <= 1'b1;
                end else begin
                    r_cz  <= CRD_W'(r_h);
                    r_neg <= 1'b0;
                end
            end
            ST_CORDIC: begin
                r_cz <= w_nz;
                if (r_cnt == 5'(STEPS - 1) && r_neg) begin
                    r_cx <= -w_nx;
                    r_cy <= -w_ny;
                end else begin
                    r_cx <= w_nx;
                    r_cy <= w_ny;
                end
            end
            ST_QMUL: begin
                if (w_mac_done) begin
                    r_qn[r_sub] <= $signed(w_acc[61:30]);
                end
            end
            ST_SQ: begin
                if (w_mac_done) begin
                    if (r_sub == 2'd0) begin
                        r_sq <= w_acc[31:0];
                    end else begin
                        r_rad <= {w_sqsum, 32'd0};
                        r_res <= '0;
                        r_bit <= 64'h4000_0000_0000_0000;
                    end
                end
            end
            ST_SQRT: begin
                if (w_ge) begin
                    r_rad <= r_rad - w_try;
                end
                r_res <= w_res_next;
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_len <= w_res_next[32:0];
                end
            end
            ST_DIV: begin
                if (!r_wait) begin
                    r_rem <= 35'({w_mag, 15'd0});
                    r_quo <= '0;
                end else begin
                    r_rem <= w_ge_d ? w_rem2 - {2'b00, r_len} : w_rem2;
                    r_quo <= w_qn;
                    if (r_cnt == 5'd30) begin
                        r_u[r_sub] <= r_move[r_sub][15] ? -w_uq : w_uq;
                    end
                end
            end
            ST_CROSS1: begin
                if (w_mac_done) begin
                    r_uv[r_sub] <= w_hi;
                end
            end
            ST_CROSS2: begin
                if (w_mac_done) begin
                    r_uuv[r_sub] <= w_hi;
                end
            end
            ST_TWIST: begin
                if (w_mac_done) begin
                    r_v <= 38'(r_u[r_sub]) + 38'(w_t2);
                end
            end
            ST_DONE: begin
                if (w_load_out) begin
                    r_oq   <= r_q;
                    r_opos <= r_pos;
                end
            end
            default: begin
                r_neg <= r_neg;
            end
        endcase
    end

    assign i_tick.ready  = (r_state == ST_IDLE);
    assign o_pose.valid  = r_out_valid;
    assign o_pose.quat_w = r_oq[0];
    assign o_pose.quat_x = r_oq[1];
    assign o_pose.quat_y = r_oq[2];
    assign o_pose.quat_z = r_oq[3];
    assign o_pose.pos_x  = $signed(r_opos[0]);
    assign o_pose.pos_y  = $signed(r_opos[1]);
    assign o_pose.pos_z  = $signed(r_opos[2]);

    a_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_done |-> (r_state == ST_ANGLE || r_state == ST_QMUL || r_state == ST_SQ ||
                        r_state == ST_CROSS1 || r_state == ST_CROSS2 ||
                        r_state == ST_TWIST || r_state == ST_STEP))
        else $error("multiply result arrived outside a multiply step");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !o_pose.ready) |=> r_state == ST_DONE)
        else $error("finished beat left the sequencer while the output was full");

    a_lane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV || r_state == ST_CROSS1 || r_state == ST_CROSS2 ||
         r_state == ST_TWIST || r_state == ST_STEP) |-> r_sub != 2'd3)
        else $error("vector lane index out of range");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("output register loaded outside the final step");

endmodule
